/* hw/rtl/gem_pkg.sv */
// gem_pkg: shared types and constants for the GF(4093) elimination unit.
// No dependencies.
package gem_pkg;
    localparam int unsigned PRIME_Q = 4093;
    localparam logic [11:0] PRIME_V = 12'd4093;
    localparam logic [11:0] INV_EXP = 12'd4091;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_RUN   = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_ROWS   = 3'd0,
        REG_COLS   = 3'd1,
        REG_PIVOTS = 3'd2,
        REG_SWAP   = 3'd3,
        REG_BACK   = 3'd4
    } t_reg;

    // a*b mod q for a,b < q; 24-bit product reduced by 2^12 = 3 (mod q)
    function automatic logic [11:0] gf_mul(input logic [11:0] a, input logic [11:0] b);
        logic [23:0] p;
        logic [14:0] s1;
        logic [12:0] s2;
        logic [12:0] s3;
        p  = a * b;
        s1 = {3'd0, p[11:0]} + 15'(p[23:12]) * 15'd3;
        s2 = 13'(s1[11:0]) + 13'(s1[14:12]) * 13'd3;
        s3 = (s2 >= 13'(PRIME_Q)) ? s2 - 13'(PRIME_Q) : s2;
        gf_mul = (s3[11:0] >= PRIME_V) ? s3[11:0] - PRIME_V : s3[11:0];
    endfunction

    function automatic logic [11:0] gf_add(input logic [11:0] a, input logic [11:0] b);
        logic [12:0] s;
        s = {1'b0, a} + {1'b0, b};
        gf_add = (s >= 13'(PRIME_Q)) ? 12'(s - 13'(PRIME_Q)) : s[11:0];
    endfunction

    function automatic logic [11:0] gf_sub(input logic [11:0] a, input logic [11:0] b);
        gf_sub = (a >= b) ? a - b : 12'(13'(a) + 13'(PRIME_Q) - 13'(b));
    endfunction
endpackage

/* hw/rtl/gaussian_elimination_mod_prime_unit.sv */
// gaussian_elimination_mod_prime_unit: top level, command handling, matrix memory and
// the elimination sequencer. Depends on gem_pkg and gem_inv.
//
// Write and read transactions take one memory access each: a write is answered
// the cycle after acceptance, an in-range read once the registered memory read
// has passed through S_RDWAIT. A run transaction walks the row-by-column loop
// nest with every entry access going through the single memory port; each
// read-modify-write runs through read states and then a write state, and each
// pivot waits in S_INV for the inverse. No input is accepted while a run or a
// pending result holds the block. The memory is not cleared by reset.
module gaussian_elimination_mod_prime_unit
    import gem_pkg::*;
#(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [4:0]  i_row,
    input  logic [7:0]  i_col,
    input  logic [11:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_read_value,
    output logic        o_status,
    output logic [5:0]  o_swap_index,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW = RW + CW;

    typedef enum logic [4:0] {
        S_IDLE, S_RDWAIT, S_OUT, S_PSTART, S_ZRD, S_ZCHK,
        S_SWRA, S_SWRB, S_SWWA, S_SWWB,
        S_PVRD, S_PVCHK, S_ADDRA, S_ADDRB, S_ADDW,
        S_INV, S_NRD, S_NW, S_FRD, S_FGET, S_ERA, S_ERB, S_EW,
        S_BFRD, S_BFGET, S_BRA, S_BRB, S_BW, S_DONE
    } t_state;

    // ---------------- configuration
    logic [5:0] r_num_rows, r_pivot_rows;
    logic [8:0] r_num_cols;
    logic       r_swap_en, r_back_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows   <= 6'd1;
            r_num_cols   <= 9'd1;
            r_pivot_rows <= 6'd0;
            r_swap_en    <= 1'b0;
            r_back_en    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROWS:   r_num_rows   <= i_cfg_data[5:0];
                REG_COLS:   r_num_cols   <= i_cfg_data;
                REG_PIVOTS: r_pivot_rows <= i_cfg_data[5:0];
                REG_SWAP:   r_swap_en    <= i_cfg_data[0];
                REG_BACK:   r_back_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- memory, one port, registered read
    logic [11:0] mem [MAX_ROWS*MAX_COLS];
    logic [11:0] r_rdata;
    logic        m_we;
    logic [AW-1:0] m_addr;
    logic [11:0] m_wdata;

    always_ff @(posedge i_clk) begin
        if (m_we) mem[m_addr] <= m_wdata;
        r_rdata <= mem[m_addr];
    end

    // ---------------- sequencer state
    t_state r_state, n_state;
    logic [6:0]  r_nr, r_np, r_pr, r_r2;   // effective sizes, pivot, row walker
    logic [9:0]  r_nc, r_c;
    logic [11:0] r_t, r_f, r_inv, r_z;
    logic [5:0]  r_ret;
    logic [11:0] r_o_val;
    logic        r_o_stat;
    logic [5:0]  r_o_swap;
    logic        inv_start, inv_done;
    logic [11:0] inv_val;

    // the pivot is on the read data in the cycle that starts the inverse
    gem_inv u_inv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (inv_start),
        .i_x     (r_rdata),
        .o_done  (inv_done),
        .o_inv   (inv_val)
    );

    function automatic logic [AW-1:0] addr(input logic [6:0] r, input logic [9:0] c);
        addr = {r[RW-1:0], c[CW-1:0]};
    endfunction

    logic in_range;
    assign in_range = (32'(i_row) < 32'(MAX_ROWS)) && (32'(i_col) < 32'(MAX_COLS));
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_OUT);
    assign o_read_value = r_o_val;
    assign o_status     = r_o_stat;
    assign o_swap_index = r_o_swap;

    logic last_col, last_row, last_above;
    logic bw_at_pivot, bw_row_end;
    assign last_col   = (r_c + 10'd1 >= r_nc);
    assign last_row   = (r_r2 + 7'd1 >= r_nr);
    assign last_above = (r_r2 + 7'd1 >= r_pr);
    // back substitution row: pivot column first, then columns from np on
    assign bw_at_pivot = (r_c == 10'(r_pr) - 10'd1);
    assign bw_row_end  = bw_at_pivot ? (10'(r_np) >= r_nc) : last_col;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) begin
                case (t_cmd'(i_cmd))
                    CMD_READ: n_state = in_range ? S_RDWAIT : S_OUT;
                    CMD_RUN:  n_state = S_PSTART;
                    default:  n_state = S_OUT;
                endcase
            end
            S_RDWAIT: n_state = S_OUT;
            S_OUT:    if (i_ready) n_state = S_IDLE;
            S_PSTART: begin
                if (r_pr >= r_np) n_state = r_back_en ? S_BFRD : S_DONE;
                else if (r_swap_en) n_state = S_ZRD;
                else n_state = S_PVRD;
            end
            S_ZRD:  n_state = S_ZCHK;
            S_ZCHK: begin
                if (!last_row) n_state = S_ZRD;
                else if ((r_z | r_rdata) == 12'd0) n_state = S_SWRA;
                else n_state = S_PVRD;
            end
            S_SWRA: n_state = S_SWRB;
            S_SWRB: n_state = S_SWWA;
            S_SWWA: n_state = S_SWWB;
            S_SWWB: n_state = last_row ? S_PVRD : S_SWRA;
            S_PVRD: n_state = S_PVCHK;
            S_PVCHK: begin
                if (r_rdata != 12'd0) n_state = S_INV;
                else if (last_row) n_state = S_DONE;
                else n_state = S_ADDRA;
            end
            S_ADDRA: n_state = S_ADDRB;
            S_ADDRB: n_state = S_ADDW;
            S_ADDW:  n_state = last_col ? S_PVRD : S_ADDRA;
            S_INV:   if (inv_done) n_state = S_NRD;
            S_NRD:   n_state = S_NW;
            S_NW:    n_state = last_col ? (last_row ? S_PSTART : S_FRD) : S_NRD;
            S_FRD:   n_state = S_FGET;
            S_FGET:  n_state = S_ERA;
            S_ERA:   n_state = S_ERB;
            S_ERB:   n_state = S_EW;
            S_EW:    n_state = last_col ? (last_row ? S_PSTART : S_FRD) : S_ERA;
            S_BFRD: begin
                if (r_pr == 7'd0) n_state = S_DONE;
                else if (last_above) n_state = S_BFRD;
                else n_state = S_BFGET;
            end
            S_BFGET: n_state = S_BRA;
            S_BRA:   n_state = S_BRB;
            S_BRB:   n_state = S_BW;
            S_BW:    n_state = bw_row_end ? S_BFRD : S_BRA;
            S_DONE:  n_state = S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // memory port and inverse start
    always_comb begin
        m_we      = 1'b0;
        m_addr    = addr(7'(i_row), 10'(i_col));
        m_wdata   = (i_value >= PRIME_V) ? i_value - PRIME_V : i_value;
        inv_start = 1'b0;
        case (r_state)
            S_IDLE:  m_we = i_valid && (t_cmd'(i_cmd) == CMD_WRITE) && in_range;
            S_ZRD:   m_addr = addr(r_r2, 10'(r_pr));
            S_SWRA:  m_addr = addr(r_r2, 10'(r_pr));
            S_SWRB:  m_addr = addr(r_r2, r_nc - 10'd1);
            S_SWWA: begin
                m_we = 1'b1; m_addr = addr(r_r2, 10'(r_pr)); m_wdata = r_rdata;
            end
            S_SWWB: begin
                m_we = 1'b1; m_addr = addr(r_r2, r_nc - 10'd1); m_wdata = r_t;
            end
            S_PVRD:  m_addr = addr(r_pr, 10'(r_pr));
            S_ADDRA: m_addr = addr(r_pr, r_c);
            S_ADDRB: m_addr = addr(r_r2, r_c);
            S_ADDW: begin
                m_we = 1'b1; m_addr = addr(r_pr, r_c); m_wdata = gf_add(r_t, r_rdata);
            end
            S_PVCHK: inv_start = (r_rdata != 12'd0);
            S_NRD:   m_addr = addr(r_pr, r_c);
            S_NW: begin
                m_we = 1'b1; m_addr = addr(r_pr, r_c); m_wdata = gf_mul(r_rdata, r_inv);
            end
            S_FRD:   m_addr = addr(r_r2, 10'(r_pr));
            S_ERA:   m_addr = addr(r_pr, r_c);
            S_ERB:   m_addr = addr(r_r2, r_c);
            S_EW: begin
                m_we = 1'b1; m_addr = addr(r_r2, r_c);
                m_wdata = gf_sub(r_rdata, r_t);
            end
            S_BFRD:  m_addr = addr(r_r2, 10'(r_pr) - 10'd1);
            S_BRA:   m_addr = addr(r_pr - 7'd1, r_c);
            S_BRB:   m_addr = addr(r_r2, r_c);
            S_BW: begin
                m_we = 1'b1; m_addr = addr(r_r2, r_c); m_wdata = gf_sub(r_rdata, r_t);
            end
            default: ;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            S_IDLE: if (i_valid) begin
                r_o_val  <= 12'd0;
                r_o_stat <= 1'b0;
                r_o_swap <= 6'd0;
                if (t_cmd'(i_cmd) == CMD_RUN) begin
                    // saturate dimensions
                    logic [6:0] nr, np;
                    logic [9:0] nc;
                    nr = (r_num_rows == 6'd0) ? 7'd1 :
                         (32'(r_num_rows) > MAX_ROWS) ? 7'(MAX_ROWS) : 7'(r_num_rows);
                    nc = (r_num_cols == 9'd0) ? 10'd1 :
                         (32'(r_num_cols) > MAX_COLS) ? 10'(MAX_COLS) : 10'(r_num_cols);
                    np = 7'(r_pivot_rows);
                    if (np > nr) np = nr;
                    if (10'(np) > nc) np = 7'(nc);
                    r_nr  <= nr;
                    r_nc  <= nc;
                    r_np  <= np;
                    r_pr  <= 7'd0;
                    r_ret <= r_swap_en ? 6'(nr) : 6'd0;
                end
            end
            S_RDWAIT: r_o_val <= r_rdata;
            S_PSTART: begin
                r_r2 <= (r_pr >= r_np) ? 7'd0 : r_pr;
                r_z  <= 12'd0;
                if (r_pr >= r_np) r_pr <= r_np;
            end
            S_ZCHK: begin
                r_z <= r_z | r_rdata;
                if (!last_row) r_r2 <= r_r2 + 7'd1;
                else if ((r_z | r_rdata) == 12'd0) begin
                    // swap walks every row from the top
                    r_r2  <= 7'd0;
                    r_ret <= 6'(r_pr);
                end else begin
                    r_r2 <= r_pr;
                end
            end
            S_ZRD: ;
            S_SWRB: r_t <= r_rdata;
            S_SWWB: r_r2 <= last_row ? r_pr : r_r2 + 7'd1;
            S_PVCHK: begin
                r_t <= r_rdata;
                if (r_rdata == 12'd0) begin
                    r_r2 <= r_r2 + 7'd1;
                    r_c  <= 10'(r_pr);
                end else begin
                    r_r2 <= r_pr;
                    r_c  <= 10'(r_pr);
                end
            end
            S_ADDRB: r_t <= r_rdata;
            S_ADDW:  if (!last_col) r_c <= r_c + 10'd1;
            S_INV:   if (inv_done) r_inv <= inv_val;
            S_NW: begin
                r_c  <= last_col ? 10'(r_pr) : r_c + 10'd1;
                if (last_col) begin
                    r_r2 <= r_pr + 7'd1;
                    if (last_row) r_pr <= r_pr + 7'd1;
                end
            end
            S_FGET: r_f <= r_rdata;
            S_ERA:  r_t <= 12'd0;
            S_ERB:  r_t <= gf_mul(r_rdata, r_f);
            S_EW: begin
                r_c <= last_col ? 10'(r_pr) : r_c + 10'd1;
                if (last_col) begin
                    r_r2 <= r_r2 + 7'd1;
                    if (last_row) r_pr <= r_pr + 7'd1;
                end
            end
            S_BFRD: begin
                if (r_pr != 7'd0 && last_above) begin
                    r_pr <= r_pr - 7'd1;
                    r_r2 <= 7'd0;
                end
            end
            S_BFGET: begin
                r_f <= r_rdata;
                r_c <= 10'(r_pr) - 10'd1;
            end
            S_BRB: r_t <= gf_mul(r_rdata, r_f);
            S_BW: begin
                if (bw_at_pivot) r_c <= 10'(r_np);
                else r_c <= r_c + 10'd1;
                if (bw_row_end) r_r2 <= r_r2 + 7'd1;
            end
            S_DONE: r_o_swap <= r_ret;
            default: ;
        endcase
        // singular: pivot stayed zero after the last lower row
        if (r_state == S_PVCHK && r_rdata == 12'd0 && last_row) begin
            r_o_stat <= 1'b1;
            r_ret    <= 6'd0;
        end
    end

    // ERA reads pivot row; its data is needed at ERB time, handled by r_t path
    // (S_ERB multiplies the pivot-row entry by the factor, S_EW subtracts from row r2)

    // ---------------- assertions
    a_one_handshake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_write_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_we && r_state == S_IDLE) |-> (i_valid && o_ready))
        else $error("idle write without transaction");
    a_inv_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        inv_start |=> (r_state == S_INV)) else $error("inverse started out of place");
    a_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_swap_index == 6'd0))
        else $error("swap index on singular result");
endmodule

/* hw/rtl/gem_inv.sv */
// gem_inv: iterative field inverse by square-and-multiply, one step a cycle.
// Depends on gem_pkg.
module gem_inv
    import gem_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [11:0] i_x,
    output logic        o_done,
    output logic [11:0] o_inv
);
    logic [11:0] r_acc, r_base, r_exp;
    logic        r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_acc  <= 12'd1;
                r_base <= i_x;
                r_exp  <= INV_EXP;
            end else if (r_busy) begin
                if (r_exp[0]) r_acc <= gf_mul(r_acc, r_base);
                r_base <= gf_mul(r_base, r_base);
                r_exp  <= r_exp >> 1;
                if (r_exp == 12'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // o_done is registered together with the last step's result in r_acc
    assign o_done = r_done;
    assign o_inv  = r_acc;
endmodule

/* tb/gaussian_elimination_mod_prime_unit_test.sv */
// Testbench for gaussian_elimination_mod_prime_unit: directed and random
// write/read/run transactions checked against an in-bench GF(4093) predictor.
// Depends on gem_pkg and the unit RTL.
`timescale 1ns / 1ps

module gaussian_elimination_mod_prime_unit_test;
    import gem_pkg::*;

    localparam int ROWS_MAX = 32;
    localparam int COLS_MAX = 256;
    localparam int Q = 4093;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        t_cmd        cmd;
        logic [4:0]  row;
        logic [7:0]  col;
        logic [11:0] value;
    } t_entry_op;

    typedef struct {
        logic [11:0] read_value;
        logic        status;
        logic [5:0]  swap_index;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_cmd;
    logic [4:0]  i_row;
    logic [7:0]  i_col;
    logic [11:0] i_value;
    logic        o_valid;
    logic        i_ready;
    logic [11:0] o_read_value;
    logic        o_status;
    logic [5:0]  o_swap_index;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [8:0]  i_cfg_data;

    gaussian_elimination_mod_prime_unit dut (.*);

    // Predictor state: matrix copy and raw register values
    logic [11:0] mat [ROWS_MAX][COLS_MAX];
    bit          written [ROWS_MAX][COLS_MAX];
    int unsigned reg_rows, reg_cols, reg_pivots, reg_swap, reg_back;

    t_entry_op pending_ops[$];
    t_answer   answers_due[$];

    int  mismatches;
    int  cycles;
    bit  took;          // an input transaction was accepted at the last rising edge
    int  send_gap;
    int  recv_gap;
    int  hold_left;     // long receiver hold-off, set by the stimulus
    bit  quiet;         // no idling in the final part of the run
    int  items;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---------------- GF(4093) predictor ----------------
    function automatic int gf_inverse(int x);
        int e;
        int acc;
        int b;
        e = Q - 2;
        acc = 1;
        b = x % Q;
        while (e != 0) begin
            if (e & 1) acc = (acc * b) % Q;
            b = (b * b) % Q;
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic int eff_rows();
        return (reg_rows < 1) ? 1 : (reg_rows > ROWS_MAX) ? ROWS_MAX : reg_rows;
    endfunction

    function automatic int eff_cols();
        return (reg_cols < 1) ? 1 : (reg_cols > COLS_MAX) ? COLS_MAX : reg_cols;
    endfunction

    // Returns -1 when a pivot stays zero, else the swap index
    function automatic int eliminate();
        int nr;
        int nc;
        int np;
        int res;
        int p;
        int inv;
        int f;
        int z;
        logic [11:0] t;
        nr = eff_rows();
        nc = eff_cols();
        np = reg_pivots;
        if (np > nr) np = nr;
        if (np > nc) np = nc;
        res = reg_swap ? nr : 0;
        for (int r = 0; r < np; r++) begin
            if (reg_swap) begin
                z = 0;
                for (int r2 = r; r2 < nr; r2++) z |= mat[r2][r];
                if (z == 0) begin
                    // pivot column empty from here down: trade it for the last column
                    res = r;
                    for (int i = 0; i < nr; i++) begin
                        t = mat[i][r];
                        mat[i][r] = mat[i][nc-1];
                        mat[i][nc-1] = t;
                    end
                end
            end
            // zero pivot: fold lower rows in while it stays zero
            for (int r2 = r + 1; r2 < nr; r2++)
                if (mat[r][r] == 0)
                    for (int c = r; c < nc; c++)
                        mat[r][c] = 12'((int'(mat[r][c]) + int'(mat[r2][c])) % Q);
            p = mat[r][r];
            if (p == 0) return -1;
            inv = gf_inverse(p);
            for (int c = r; c < nc; c++) mat[r][c] = 12'((int'(mat[r][c]) * inv) % Q);
            for (int r2 = r + 1; r2 < nr; r2++) begin
                f = mat[r2][r];
                for (int c = r; c < nc; c++)
                    mat[r2][c] = 12'((Q + int'(mat[r2][c]) - (int'(mat[r][c]) * f) % Q) % Q);
            end
        end
        if (reg_back == 0) return res;
        for (int r = np - 1; r >= 0; r--)
            for (int r2 = 0; r2 < r; r2++) begin
                f = mat[r2][r];
                mat[r2][r] = 12'((Q + int'(mat[r2][r]) - (int'(mat[r][r]) * f) % Q) % Q);
                for (int c = np; c < nc; c++)
                    mat[r2][c] = 12'((Q + int'(mat[r2][c]) - (int'(mat[r][c]) * f) % Q) % Q);
            end
        return res;
    endfunction

    // ---------------- input driver ----------------
    always @(posedge i_clk) begin
        t_answer a;
        int      res;
        took <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            a = '{read_value: '0, status: 1'b0, swap_index: '0};
            case (t_cmd'(i_cmd))
                CMD_WRITE: mat[i_row][i_col] = 12'(int'(i_value) % Q);
                CMD_READ:  a.read_value = mat[i_row][i_col];
                CMD_RUN: begin
                    res = eliminate();
                    if (res < 0) a.status = 1'b1;
                    else a.swap_index = 6'(res);
                end
                default: ;
            endcase
            answers_due.push_back(a);
        end
    end

    always @(negedge i_clk) begin
        t_entry_op op;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || took) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                op = pending_ops.pop_front();
                i_cmd   <= op.cmd;
                i_row   <= op.row;
                i_col   <= op.col;
                i_value <= op.value;
                i_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 8);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------- result receiver ----------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_ready  <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 8);
        end
    end

    // ---------------- result monitor ----------------
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && o_valid && i_ready) begin
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: rv=%0d st=%0d sw=%0d",
                             o_read_value, o_status, o_swap_index);
            end else begin
                a = answers_due.pop_front();
                if (o_read_value !== a.read_value || o_status !== a.status ||
                        o_swap_index !== a.swap_index) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp rv=%0d st=%0d sw=%0d, got rv=%0d st=%0d sw=%0d",
                                 a.read_value, a.status, a.swap_index,
                                 o_read_value, o_status, o_swap_index);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** gaussian_elimination_mod_prime_unit: FAILED **");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic push_op(t_cmd cmd, int row, int col, int value);
        pending_ops.push_back('{cmd: cmd, row: 5'(row), col: 8'(col), value: 12'(value)});
        if (cmd == CMD_WRITE) written[row][col] = 1'b1;
        items++;
    endtask

    function automatic int rand_element();
        int k;
        k = $urandom_range(0, 19);
        if (k < 5) return 0;
        if (k == 5) return $urandom_range(Q, 4095);   // noncanonical, stored reduced
        return $urandom_range(0, 4095);
    endfunction

    // waits until the unit has answered everything handed to it
    task automatic drain();
        do begin
            @(negedge i_clk);
            #1;
        end while (pending_ops.size() != 0 || i_valid || answers_due.size() != 0);
        repeat (5) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_reg idx, int data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 9'(data);
        case (idx)
            REG_ROWS:   reg_rows   = data & 'h3F;
            REG_COLS:   reg_cols   = data & 'h1FF;
            REG_PIVOTS: reg_pivots = data & 'h3F;
            REG_SWAP:   reg_swap   = data & 1;
            REG_BACK:   reg_back   = data & 1;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_shape(int rows, int cols, int pivots, int swp, int bck);
        drain();
        cfg_write(REG_ROWS, rows);
        cfg_write(REG_COLS, cols);
        cfg_write(REG_PIVOTS, pivots);
        cfg_write(REG_SWAP, swp);
        cfg_write(REG_BACK, bck);
    endtask

    // a run touches the whole active region, so every entry there gets a value first
    task automatic fill_region();
        for (int r = 0; r < eff_rows(); r++)
            for (int c = 0; c < eff_cols(); c++)
                if (!written[r][c]) push_op(CMD_WRITE, r, c, rand_element());
    endtask

    task automatic random_phase(int n);
        int nr;
        int nc;
        int k;
        int zc;
        nr = eff_rows();
        nc = eff_cols();
        fill_region();
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 40) begin
                push_op(CMD_WRITE, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                        rand_element());
            end else if (k < 46) begin
                push_op(CMD_WRITE, $urandom_range(0, 31), $urandom_range(0, 255),
                        $urandom_range(0, 4095));
            end else if (k < 78) begin
                push_op(CMD_READ, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1), 0);
            end else if (k < 84) begin
                // clear a column below its diagonal to provoke a swap or a singular stop
                zc = $urandom_range(0, nc - 1);
                for (int r = (zc < nr ? zc : 0); r < nr; r++) push_op(CMD_WRITE, r, zc, 0);
                push_op(CMD_RUN, 0, 0, 0);
            end else if (k < 96) begin
                push_op(CMD_RUN, $urandom_range(0, 31), $urandom_range(0, 255), 0);
            end else begin
                push_op(CMD_NONE, $urandom_range(0, 31), $urandom_range(0, 255),
                        $urandom_range(0, 4095));
            end
        end
        // read back part of the result
        for (int i = 0; i < 4; i++)
            push_op(CMD_READ, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1), 0);
    endtask

    initial begin
        int nr;
        int np;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_cmd = '0;
        i_row = '0;
        i_col = '0;
        i_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        took = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        hold_left = 0;
        quiet = 1'b0;
        mismatches = 0;
        cycles = 0;
        items = 0;
        reg_rows = 1;
        reg_cols = 1;
        reg_pivots = 0;
        reg_swap = 0;
        reg_back = 1;
        for (int r = 0; r < ROWS_MAX; r++)
            for (int c = 0; c < COLS_MAX; c++) begin
                mat[r][c] = '0;
                written[r][c] = 1'b0;
            end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, noncanonical value, unused command, reset config run
        push_op(CMD_WRITE, 0, 0, Q - 1);
        push_op(CMD_READ, 0, 0, 0);
        push_op(CMD_WRITE, 31, 255, 0);
        push_op(CMD_READ, 31, 255, 0);
        push_op(CMD_WRITE, 5, 7, 4095);
        push_op(CMD_READ, 5, 7, 0);
        push_op(CMD_WRITE, 10, 128, Q);
        push_op(CMD_READ, 10, 128, 0);
        push_op(CMD_NONE, 31, 255, 4095);
        push_op(CMD_RUN, 0, 0, 0);
        push_op(CMD_READ, 0, 0, 0);

        // directed: 3x4 with a zero first column, swap and back substitution
        set_shape(3, 4, 3, 1, 1);
        fill_region();
        push_op(CMD_WRITE, 0, 0, 0);
        push_op(CMD_WRITE, 1, 0, 0);
        push_op(CMD_WRITE, 2, 0, 0);
        push_op(CMD_RUN, 0, 0, 0);
        for (int c = 0; c < 4; c++) push_op(CMD_READ, 1, c, 0);
        // directed: all-zero matrix is singular
        set_shape(2, 2, 2, 0, 0);
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < 2; c++) push_op(CMD_WRITE, r, c, 0);
        push_op(CMD_RUN, 0, 0, 0);
        push_op(CMD_READ, 1, 1, 0);
        // directed: zero pivot rescued by a lower row
        push_op(CMD_WRITE, 1, 0, 3);
        push_op(CMD_WRITE, 1, 1, 1);
        push_op(CMD_RUN, 0, 0, 0);

        // out-of-range dimensions saturate; unknown register indexes ignored
        set_shape(0, 0, 40, 1, 1);
        cfg_write(t_reg'(3'd5), 9'h1FF);
        cfg_write(t_reg'(3'd7), 9'h155);
        random_phase(6);

        // row count above the store saturates to the full height
        set_shape(63, 2, 40, 1, 1);
        random_phase(6);
        set_shape(8, 8, 8, 0, 1);
        random_phase(10);

        // long receiver hold-off while the sender keeps offering
        set_shape(4, 5, 4, 1, 1);
        hold_left = 400;
        random_phase(30);

        for (int ph = 0; ph < 12; ph++) begin
            nr = $urandom_range(1, 8);
            np = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, nr);
            if (ph == 11) begin
                drain();
                quiet = 1'b1;
            end
            set_shape(nr, $urandom_range(1, 10), np, $urandom_range(0, 1), $urandom_range(0, 1));
            random_phase(12);
        end

        drain();
        repeat (50) @(negedge i_clk);
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("** gaussian_elimination_mod_prime_unit: PASSED **");
        end else begin
            $display("** gaussian_elimination_mod_prime_unit: FAILED **");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/gem_pkg.sv
hw/rtl/gem_inv.sv
hw/rtl/gaussian_elimination_mod_prime_unit.sv
tb/gaussian_elimination_mod_prime_unit_test.sv
